// ===== rtl/lrupr_pkg.sv =====
package lrupr_pkg;

    localparam int FRAMES     = 8;
    localparam int PAGE_BITS  = 20;
    localparam int FRAME_W    = $clog2(FRAMES);
    localparam int CNT_W      = $clog2(FRAMES + 1);
    localparam int RANK_W     = FRAME_W;
    localparam int CFG_W      = 4;
    localparam int FAULT_W    = 32;
    localparam int OUT_FIELDS_W = 1 + FRAME_W + 1 + PAGE_BITS + FAULT_W;
    localparam int IN_TDATA_W  = ((PAGE_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(FRAMES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_VICTIM,
        ST_COMMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic idx_inc;
        logic idx_clr;
        logic set_hit;
        logic vic_step;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic match;
        logic full;
        logic vic_last;
        logic out_free;
    } t_status;

endpackage

// ===== rtl/lrupr_ctrl.sv =====
module lrupr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  lrupr_pkg::t_status i_status,
    output lrupr_pkg::t_cmd    o_cmd
);

    lrupr_pkg::t_state r_state;
    lrupr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lrupr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            lrupr_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = lrupr_pkg::ST_SCAN;
                end
            end
            lrupr_pkg::ST_SCAN: begin
                if (i_status.scan_done) begin
                    // miss: pick victim only when all active frames are taken
                    if (i_status.full) begin
                        o_cmd.idx_clr = 1'b1;
                        n_state       = lrupr_pkg::ST_VICTIM;
                    end else begin
                        n_state = lrupr_pkg::ST_COMMIT;
                    end
                end else if (i_status.match) begin
                    o_cmd.set_hit = 1'b1;
                    n_state       = lrupr_pkg::ST_COMMIT;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            lrupr_pkg::ST_VICTIM: begin
                o_cmd.vic_step = 1'b1;
                o_cmd.idx_inc  = 1'b1;
                if (i_status.vic_last) begin
                    n_state = lrupr_pkg::ST_COMMIT;
                end
            end
            lrupr_pkg::ST_COMMIT: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = lrupr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lrupr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/lrupr_dp.sv =====
module lrupr_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [lrupr_pkg::CFG_W-1:0]          i_cfg_wdata,
    input  logic [lrupr_pkg::PAGE_BITS-1:0]      i_page,
    input  lrupr_pkg::t_cmd                      i_cmd,
    output lrupr_pkg::t_status                   o_status,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic [lrupr_pkg::OUT_TDATA_W-1:0]    o_out_data
);

    localparam int FR  = lrupr_pkg::FRAMES;
    localparam int FW  = lrupr_pkg::FRAME_W;
    localparam int CW  = lrupr_pkg::CNT_W;
    localparam int RW  = lrupr_pkg::RANK_W;
    localparam int PW  = lrupr_pkg::PAGE_BITS;
    localparam int QW  = lrupr_pkg::FAULT_W;
    localparam int OW  = lrupr_pkg::OUT_TDATA_W;
    localparam int PAD = OW - lrupr_pkg::OUT_FIELDS_W;

    logic [lrupr_pkg::CFG_W-1:0] r_cfg;
    logic [PW-1:0]               r_page;
    logic [CW-1:0]               r_idx;
    logic                        r_hit;
    logic [FW-1:0]               r_sel;
    logic [RW-1:0]               r_worst;
    logic [PW-1:0]               r_frame_page [FR];
    logic [RW-1:0]               r_rank [FR];
    logic [CW-1:0]               r_filled;
    logic [QW-1:0]               r_fault;
    logic                        r_out_valid;
    logic [OW-1:0]               r_out_data;

    logic [CW-1:0]  active_n;
    logic [CW-1:0]  searched;
    logic           full;
    logic           fill;
    logic [FW-1:0]  tgt;
    logic [RW-1:0]  tgt_rank;
    logic [CW-1:0]  touch_lim;
    logic [QW-1:0]  n_fault;
    logic [PW-1:0]  ev_page;
    logic [RW-1:0]  n_rank [FR];
    logic [RW-1:0]  cur_rank;

    // frames_in_use clamped to 1..FRAMES
    always_comb begin
        if (r_cfg == '0) begin
            active_n = CW'(1);
        end else if (r_cfg > lrupr_pkg::CFG_W'(FR)) begin
            active_n = CW'(FR);
        end else begin
            active_n = CW'(r_cfg);
        end
    end

    assign searched = (r_filled < active_n) ? r_filled : active_n;
    assign full     = (r_filled >= active_n);
    assign fill     = !r_hit && !full;
    assign cur_rank = r_rank[r_idx[FW-1:0]];

    assign o_status.scan_done = (r_idx == searched);
    assign o_status.match     = (r_frame_page[r_idx[FW-1:0]] == r_page);
    assign o_status.full      = full;
    assign o_status.vic_last  = (r_idx == active_n - CW'(1));
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    // commit: target frame, its reference rank and the touched range
    always_comb begin
        if (fill) begin
            tgt       = r_filled[FW-1:0];
            tgt_rank  = r_filled[RW-1:0];
            touch_lim = r_filled + CW'(1);
        end else begin
            tgt       = r_sel;
            tgt_rank  = r_rank[r_sel];
            touch_lim = r_filled;
        end
        ev_page = (!r_hit && !fill) ? r_frame_page[r_sel] : '0;
        if (!r_hit && (r_fault != '1)) begin
            n_fault = r_fault + QW'(1);
        end else begin
            n_fault = r_fault;
        end
        for (int g = 0; g < FR; g++) begin
            if (g == int'(tgt)) begin
                n_rank[g] = '0;
            end else if ((CW'(g) < touch_lim) && (r_rank[g] < tgt_rank)) begin
                n_rank[g] = r_rank[g] + RW'(1);
            end else begin
                n_rank[g] = r_rank[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= lrupr_pkg::CFG_RESET;
            r_filled    <= '0;
            r_fault     <= '0;
            r_out_valid <= 1'b0;
            for (int g = 0; g < FR; g++) begin
                r_rank[g] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
                r_fault     <= n_fault;
                for (int g = 0; g < FR; g++) begin
                    r_rank[g] <= n_rank[g];
                end
                if (fill) begin
                    r_filled <= r_filled + CW'(1);
                end
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_page <= i_page;
            r_hit  <= 1'b0;
        end
        if (i_cmd.set_hit) begin
            r_hit <= 1'b1;
            r_sel <= r_idx[FW-1:0];
        end
        if (i_cmd.load || i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + CW'(1);
        end
        // least recent wins, first index kept on a tie
        if (i_cmd.vic_step) begin
            if ((r_idx == '0) || (cur_rank > r_worst)) begin
                r_worst <= cur_rank;
                r_sel   <= r_idx[FW-1:0];
            end
        end
        if (i_cmd.commit) begin
            if (!r_hit) begin
                r_frame_page[tgt] <= r_page;
            end
            r_out_data <= {{PAD{1'b0}}, n_fault, ev_page, (!r_hit && !fill), tgt, r_hit};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== rtl/lru_page_replacement.sv =====
// LRU page replacement over up to eight frames. Each accepted page reference
// gives one result: hit flag, frame used, evicted page and the saturating
// fault count. Frames are compared in order until a hit or the end of the
// filled frames (at most frames_in_use); a miss on a full set then runs a
// victim search over frames_in_use frames. The frame compare and the victim
// search each go one frame per cycle through a single comparator. One
// reference is in work at a time; the result register lets the next
// reference be accepted while the previous result waits. The user must write
// frames_in_use only while idle; the block itself does not enforce this.
module lru_page_replacement (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lrupr_pkg::CFG_W-1:0]         i_cfg_wdata,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // page_number [19:0], zero fill above
    input  logic [lrupr_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // hit [0], frame_index [3:1], evicted_valid [4], evicted_page [24:5],
    // fault_count [56:25], zero fill above
    output logic [lrupr_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata
);

    lrupr_pkg::t_cmd    cmd;
    lrupr_pkg::t_status status;

    lrupr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    lrupr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_page      (i_s_axis_tdata[lrupr_pkg::PAGE_BITS-1:0]),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata)
    );

endmodule
